// ----- rtl/rar_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational add and reduce unit.
// ----------------------------------------------------------------------------
package rar_pkg;

   localparam int FieldWidth = 32;
   localparam int WordWidth  = 64;
   localparam int DenWidth   = 62;

   // work handed from the front end to the back end
   typedef struct packed {
      logic [WordWidth-1:0] nmag;
      logic [WordWidth-1:0] dmag;
      logic                 nneg;
      logic                 dneg;
      logic                 zero_den;
   } rar_work_type;

endpackage

// ----- rtl/rar_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_req_if / rar_rsp_if
// Valid/ready channels for operand and result transactions.
// ----------------------------------------------------------------------------
interface rar_req_if;
   import rar_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [FieldWidth-1:0] a_num;
   logic signed [FieldWidth-1:0] a_den;
   logic signed [FieldWidth-1:0] b_num;
   logic signed [FieldWidth-1:0] b_den;

   modport source (output valid, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_rsp_if;
   import rar_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [WordWidth-1:0] sum_num;
   logic [DenWidth-1:0]         sum_den;
   logic                        zero_den;

   modport source (output valid, sum_num, sum_den, zero_den, input ready);
   modport sink   (input valid, sum_num, sum_den, zero_den, output ready);
endinterface

// ----- rtl/rar_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_front
// Takes operands, forms magnitudes and signs, cross products and the
// numerator sum with one shared multiplier, then hands work to the queue.
// ----------------------------------------------------------------------------
module rar_front #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   rar_req_if.sink               req_chan,
   output logic                  push_valid,
   input  logic                  push_ready,
   output rar_pkg::rar_work_type push_item
);
   import rar_pkg::*;

   localparam int OW = OPERAND_WIDTH;

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_P1   = 5'b00010,
      F_P2   = 5'b00100,
      F_PD   = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   function automatic logic [OW-1:0] mag_of(input logic [FieldWidth-1:0] v);
      logic [OW-1:0] f;
      f = v[OW-1:0];
      return f[OW-1] ? (~f + 1'b1) : f;
   endfunction

   front_state_type state_ff, state_in;
   logic [OW-1:0] ma_ff, mb_ff, mc_ff, md_ff;
   logic [OW-1:0] ma_in, mb_in, mc_in, md_in;
   logic sa_ff, sb_ff, sc_ff, sd_ff;
   logic sa_in, sb_in, sc_in, sd_in;
   logic [2*OW-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic [WordWidth-1:0] pd_ff, pd_in, nmag_ff, nmag_in;
   logic nneg_ff, nneg_in, zero_ff, zero_in;

   logic [OW-1:0]        mul_a, mul_b;
   logic [2*OW-1:0]      prod;
   logic [WordWidth-1:0] p1w, p2w;
   logic                 s1, s2;

   assign req_chan.ready = (state_ff == F_IDLE);

   always_comb begin
      case (state_ff)
         F_P1: begin
            mul_a = ma_ff;
            mul_b = md_ff;
         end
         F_P2: begin
            mul_a = mc_ff;
            mul_b = mb_ff;
         end
         default: begin
            mul_a = mb_ff;
            mul_b = md_ff;
         end
      endcase
      prod = mul_a * mul_b;
      p1w  = WordWidth'(p1_ff);
      p2w  = WordWidth'(p2_ff);
      s1   = (sa_ff != sd_ff) && (p1_ff != '0);
      s2   = (sc_ff != sb_ff) && (p2_ff != '0);
   end

   always_comb begin
      state_in = state_ff;
      ma_in = ma_ff; mb_in = mb_ff; mc_in = mc_ff; md_in = md_ff;
      sa_in = sa_ff; sb_in = sb_ff; sc_in = sc_ff; sd_in = sd_ff;
      p1_in = p1_ff; p2_in = p2_ff; pd_in = pd_ff;
      nmag_in = nmag_ff; nneg_in = nneg_ff; zero_in = zero_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_chan.valid) begin
               ma_in = mag_of(req_chan.a_num);
               mb_in = mag_of(req_chan.a_den);
               mc_in = mag_of(req_chan.b_num);
               md_in = mag_of(req_chan.b_den);
               sa_in = req_chan.a_num[OW-1];
               sb_in = req_chan.a_den[OW-1];
               sc_in = req_chan.b_num[OW-1];
               sd_in = req_chan.b_den[OW-1];
               state_in = F_P1;
            end
         end
         F_P1: begin
            p1_in    = prod;
            zero_in  = (mb_ff == '0) || (md_ff == '0);
            state_in = F_P2;
         end
         F_P2: begin
            p2_in    = prod;
            state_in = F_PD;
         end
         F_PD: begin
            pd_in = WordWidth'(prod);
            if (s1 == s2) begin
               nmag_in = p1w + p2w;
               nneg_in = s1;
            end else if (p1w >= p2w) begin
               nmag_in = p1w - p2w;
               nneg_in = s1;
            end else begin
               nmag_in = p2w - p1w;
               nneg_in = s2;
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_valid         = (state_ff == F_PUSH);
   assign push_item.nmag     = nmag_ff;
   assign push_item.dmag     = pd_ff;
   assign push_item.nneg     = nneg_ff;
   assign push_item.dneg     = (sb_ff != sd_ff);
   assign push_item.zero_den = zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff <= ma_in; mb_ff <= mb_in; mc_ff <= mc_in; md_ff <= md_in;
      sa_ff <= sa_in; sb_ff <= sb_in; sc_ff <= sc_in; sd_ff <= sd_in;
      p1_ff <= p1_in; p2_ff <= p2_in; pd_ff <= pd_in;
      nmag_ff <= nmag_in; nneg_ff <= nneg_in; zero_ff <= zero_in;
   end

endmodule

// ----- rtl/rar_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_queue
// Two-entry FIFO of work between front end and back end.
// ----------------------------------------------------------------------------
module rar_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rar_pkg::rar_work_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output rar_pkg::rar_work_type pop_item
);
   import rar_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   rar_work_type          slot_ff [Depth];
   logic [PtrW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign push_ready = (cnt_ff != CntW'(Depth));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/rar_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_back
// Binary GCD, then one restoring divider reused for numerator and
// denominator, sign fix-up and the result register.
// ----------------------------------------------------------------------------
module rar_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  rar_pkg::rar_work_type pop_item,
   rar_rsp_if.source             rsp_chan
);
   import rar_pkg::*;

   localparam int ShW = $clog2(WordWidth);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_GCD  = 5'b00010,
      B_DIVN = 5'b00100,
      B_DIVD = 5'b01000,
      B_OUT  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [WordWidth-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [WordWidth-1:0] num_ff, num_in, den_ff, den_in;
   logic [WordWidth-1:0] q_ff, q_in, rem_ff, rem_in;
   logic [ShW-1:0]       k_ff, k_in, cnt_ff, cnt_in;
   logic                 nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic signed [WordWidth-1:0] onum_ff, onum_in;
   logic [DenWidth-1:0]  oden_ff, oden_in;
   logic                 ozero_ff, ozero_in;

   logic [WordWidth-1:0] trial, qnext, rnext;
   logic                 neg;

   assign pop_ready         = (state_ff == B_IDLE);
   assign rsp_chan.valid    = (state_ff == B_OUT);
   assign rsp_chan.sum_num  = onum_ff;
   assign rsp_chan.sum_den  = oden_ff;
   assign rsp_chan.zero_den = ozero_ff;

   always_comb begin
      trial = {rem_ff[WordWidth-2:0], q_ff[WordWidth-1]};
      if (trial >= g_ff) begin
         rnext = trial - g_ff;
         qnext = {q_ff[WordWidth-2:0], 1'b1};
      end else begin
         rnext = trial;
         qnext = {q_ff[WordWidth-2:0], 1'b0};
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; g_in = g_ff; k_in = k_ff;
      num_in = num_ff; den_in = den_ff;
      q_in = q_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      nneg_in = nneg_ff; dneg_in = dneg_ff;
      onum_in = onum_ff; oden_in = oden_ff; ozero_in = ozero_ff;
      neg = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               x_in    = pop_item.nmag;
               y_in    = pop_item.dmag;
               num_in  = pop_item.nmag;
               den_in  = pop_item.dmag;
               nneg_in = pop_item.nneg;
               dneg_in = pop_item.dneg;
               k_in    = '0;
               if (pop_item.zero_den) begin
                  onum_in  = '0;
                  oden_in  = '0;
                  ozero_in = 1'b1;
                  state_in = B_OUT;
               end else begin
                  state_in = B_GCD;
               end
            end
         end
         B_GCD: begin
            if (x_ff == '0) begin
               g_in     = y_ff << k_ff;
               q_in     = num_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = B_DIVN;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         B_DIVN: begin
            q_in   = qnext;
            rem_in = rnext;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               num_in   = qnext;
               q_in     = den_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = B_DIVD;
            end
         end
         B_DIVD: begin
            q_in   = qnext;
            rem_in = rnext;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               neg      = (num_ff != '0) && (nneg_ff != dneg_ff);
               onum_in  = neg ? (~num_ff + 1'b1) : num_ff;
               oden_in  = qnext[DenWidth-1:0];
               ozero_in = 1'b0;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (rsp_chan.ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; g_ff <= g_in; k_ff <= k_in;
      num_ff <= num_in; den_ff <= den_in;
      q_ff <= q_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      nneg_ff <= nneg_in; dneg_ff <= dneg_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ozero_ff <= ozero_in;
   end

endmodule

// ----- rtl/rational_add_reduce_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_reduce_unit
// Adds two signed fractions and returns the sum reduced by its GCD with a
// positive denominator; a zero input denominator returns 0/0 and a flag.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        a_num a_den b_num b_den
//   rsp_chan  out  valid/ready        sum_num sum_den zero_den
//
// Front end: one shared multiplier forms three products in turn (F_P1, F_P2, F_PD).
// Back end: binary GCD, then 2 x 64 divider steps (numerator, then denominator),
// then the result register; a zero denominator goes straight to the result.
// Steady rate is set by the back end, which takes new work only when idle.
// Synchronous active-high reset clears all control; payload is not reset.
// A stalled result holds the back end; the two-entry queue lets the front
// end keep accepting until it fills.
// ----------------------------------------------------------------------------
module rational_add_reduce_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   rar_req_if.sink   req_chan,
   rar_rsp_if.source rsp_chan
);
   import rar_pkg::*;

   logic         push_valid, push_ready, pop_valid, pop_ready;
   rar_work_type push_item, pop_item;

   rar_front #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   rar_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   rar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule
